FILE: design/lls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lls_pkg
// Shared types, constants, corner sign helpers and the rounding helper for the
// linear Lagrange shape function pipeline.
// ----------------------------------------------------------------------------
package lls_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COORD_W   = 16;
  // one +- x needs one bit above the coordinate width, one - u - v - w needs two
  localparam int OPND_W    = COORD_W + 2;
  localparam int MUL_A_W   = OPND_W + 1;
  localparam int PROD_W    = 38;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic signed [OPND_W-1:0] ONE = OPND_W'(1) << FRAC_BITS;

  localparam logic [CFG_AW-1:0] REG_ELEMENT_KIND = CFG_AW'(0);

  typedef enum logic [1:0] {
    EK_TRI  = 2'd0,
    EK_QUAD = 2'd1,
    EK_TET  = 2'd2,
    EK_HEX  = 2'd3
  } elem_e;

  typedef enum logic {
    KIND_VALUE = 1'b0,
    KIND_DERIV = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    AX_NONE = 2'd0,
    AX_U    = 2'd1,
    AX_V    = 2'd2,
    AX_W    = 2'd3
  } axis_e;

  // rounding shift applied after a multiplication
  typedef enum logic [2:0] {
    SH_NONE    = 3'd0,
    SH_QUARTER = 3'd1,
    SH_FRAC    = 3'd2,
    SH_FRAC_Q  = 3'd3,
    SH_FRAC_E  = 3'd4
  } shift_e;

  // operands of the two multiplications for one word
  typedef struct packed {
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
    shift_e                   s1;
    logic signed [OPND_W-1:0] c;
    shift_e                   s2;
  } op_t;

  // corner signs: 1 means the factor is (1 + x)
  function automatic logic corner_pos_u(input logic [2:0] c);
    return (c == 3'd1) || (c == 3'd2) || (c == 3'd5) || (c == 3'd6);
  endfunction

  function automatic logic corner_pos_v(input logic [2:0] c);
    return c[1];
  endfunction

  function automatic logic corner_pos_w(input logic [2:0] c);
    return c[2];
  endfunction

  // divide by a power of two, round to nearest, ties away from zero
  function automatic logic signed [PROD_W-1:0] rnd_shift(
      input logic signed [PROD_W-1:0] x, input shift_e sh);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
    unique case (sh)
      SH_NONE:    r = mag;
      SH_QUARTER: r = (mag + (PROD_W'(1) << 1)) >> 2;
      SH_FRAC:    r = (mag + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      SH_FRAC_Q:  r = (mag + (PROD_W'(1) << (FRAC_BITS + 1))) >> (FRAC_BITS + 2);
      SH_FRAC_E:  r = (mag + (PROD_W'(1) << (FRAC_BITS + 2))) >> (FRAC_BITS + 3);
      default:    r = mag;
    endcase
    return x[PROD_W-1] ? -signed'(r) : signed'(r);
  endfunction

endpackage

FILE: design/lls_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lls_decode
// First stage: checks node and axis, forms the corner factors and picks
// the multiplier operands and rounding shifts.
// ----------------------------------------------------------------------------
module lls_decode import lls_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  elem_e                     ek_i,
  input  logic                      kind_i,
  input  logic [3:0]                node_i,
  input  logic [1:0]                axis_i,
  input  logic signed [COORD_W-1:0] coord_u_i,
  input  logic signed [COORD_W-1:0] coord_v_i,
  input  logic signed [COORD_W-1:0] coord_w_i,
  output logic                      valid_o,
  output op_t                       op_o
);

  logic                     valid_q;
  op_t                      op_d, op_q;
  logic [3:0]               cnt;
  logic [1:0]               dims;
  logic                     bad;
  logic [2:0]               c;
  logic signed [OPND_W-1:0] u, v, w, fu, fv, fw;
  logic                     pu, pv, pw;

  always_comb begin
    u = OPND_W'(coord_u_i);
    v = OPND_W'(coord_v_i);
    w = OPND_W'(coord_w_i);
    unique case (ek_i)
      EK_TRI:  cnt = 4'd3;
      EK_HEX:  cnt = 4'd8;
      default: cnt = 4'd4;
    endcase
    dims = (ek_i == EK_TET || ek_i == EK_HEX) ? 2'd3 : 2'd2;
    bad  = (node_i == 4'd0) || (node_i > cnt) ||
           ((kind_i == KIND_DERIV) && ((axis_i == AX_NONE) || (axis_i > dims)));
    c    = 3'(node_i - 4'd1);
    pu   = corner_pos_u(c);
    pv   = corner_pos_v(c);
    pw   = corner_pos_w(c);
    fu   = pu ? ONE + u : ONE - u;
    fv   = pv ? ONE + v : ONE - v;
    fw   = pw ? ONE + w : ONE - w;
  end

  always_comb begin
    op_d.a  = '0;
    op_d.b  = ONE >>> FRAC_BITS;
    op_d.s1 = SH_NONE;
    op_d.c  = ONE >>> FRAC_BITS;
    op_d.s2 = SH_NONE;
    if (!bad) begin
      unique case (ek_i)
        EK_TRI, EK_TET: begin
          if (kind_i == KIND_VALUE) begin
            priority if (node_i == 4'd1) begin
              op_d.a = u;
            end else if (node_i == 4'd2) begin
              op_d.a = v;
            end else if (node_i == 4'd3 && ek_i == EK_TET) begin
              op_d.a = w;
            end else if (ek_i == EK_TET) begin
              op_d.a = ONE - u - v - w;
            end else begin
              op_d.a = ONE - u - v;
            end
          end else begin
            priority if (node_i == cnt) begin
              op_d.a = -ONE;
            end else if (node_i == 4'(axis_i)) begin
              op_d.a = ONE;
            end else begin
              op_d.a = '0;
            end
          end
        end
        EK_QUAD: begin
          if (kind_i == KIND_VALUE) begin
            op_d.a  = fu;
            op_d.b  = fv;
            op_d.s1 = SH_FRAC_Q;
          end else begin
            op_d.s1 = SH_QUARTER;
            if (axis_i == AX_U) begin
              op_d.a = pu ? fv : -fv;
            end else begin
              op_d.a = pv ? fu : -fu;
            end
          end
        end
        default: begin
          if (kind_i == KIND_VALUE) begin
            op_d.a  = fu;
            op_d.b  = fv;
            op_d.s1 = SH_FRAC;
            op_d.c  = fw;
            op_d.s2 = SH_FRAC_E;
          end else begin
            op_d.s1 = SH_FRAC_E;
            unique case (axis_i)
              AX_U: begin
                op_d.a = pu ? fv : -fv;
                op_d.b = fw;
              end
              AX_V: begin
                op_d.a = pv ? fu : -fu;
                op_d.b = fw;
              end
              default: begin
                op_d.a = pw ? fu : -fu;
                op_d.b = fv;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;

endmodule

FILE: design/lls_mulrnd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lls_mulrnd
// Two stages: a registered signed product, then a registered rounding shift.
// ----------------------------------------------------------------------------
module lls_mulrnd import lls_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [OPND_W-1:0]  b_i,
  input  shift_e                    sh_i,
  output logic                      valid_o,
  output logic signed [PROD_W-1:0]  res_o
);

  logic                     prod_vld_q, res_vld_q;
  logic signed [PROD_W-1:0] prod_d, prod_q, res_q;
  shift_e                   sh_q;

  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      prod_vld_q <= valid_i;
      res_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sh_q   <= sh_i;
    res_q  <= rnd_shift(prod_q, sh_q);
  end

  assign valid_o = res_vld_q;
  assign res_o   = res_q;

endmodule

FILE: design/linear_lagrange_shape_function.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_lagrange_shape_function
// Linear Lagrange shape function and derivative evaluator, Q2.14 in and out.
// ----------------------------------------------------------------------------
// One word is taken every clock cycle; busy is never raised. Each result
// appears on done_o after one decode stage, two multiply-and-round units
// of two stages each (the second serves the trilinear hexahedron value),
// and a saturation register. Results are strobed for one cycle and cannot
// be held off. Write element_kind only while no words are in flight.
module linear_lagrange_shape_function import lls_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_AW-1:0]         paddr,
  input  logic [CFG_DW-1:0]         pwdata,
  output logic [CFG_DW-1:0]         prdata,
  output logic                      pready,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind_i,
  input  logic [3:0]                node_i,
  input  logic [1:0]                axis_i,
  input  logic signed [COORD_W-1:0] coord_u_i,
  input  logic signed [COORD_W-1:0] coord_v_i,
  input  logic signed [COORD_W-1:0] coord_w_i,
  output logic                      done_o,
  output logic signed [COORD_W-1:0] shape_value_o,
  output logic                      saturated_o
);

  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(32768);

  elem_e                    ek_q;
  logic                     dec_vld, m1_vld, m2_vld;
  op_t                      op;
  logic signed [PROD_W-1:0] r1, r2;
  logic signed [OPND_W-1:0] c_d1_q, c_d2_q;
  shift_e                   s2_d1_q, s2_d2_q;
  logic                     done_q, sat_q;
  logic signed [COORD_W-1:0] val_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ek_q <= EK_TRI;
    end else if (psel && penable && pwrite && pready && paddr == REG_ELEMENT_KIND) begin
      ek_q <= elem_e'(pwdata[1:0]);
    end
  end

  assign prdata = (paddr == REG_ELEMENT_KIND) ? CFG_DW'(ek_q) : '0;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  lls_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start && !busy),
    .ek_i      (ek_q),
    .kind_i    (kind_i),
    .node_i    (node_i),
    .axis_i    (axis_i),
    .coord_u_i (coord_u_i),
    .coord_v_i (coord_v_i),
    .coord_w_i (coord_w_i),
    .valid_o   (dec_vld),
    .op_o      (op)
  );

  lls_mulrnd u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_vld),
    .a_i     (MUL_A_W'(op.a)),
    .b_i     (op.b),
    .sh_i    (op.s1),
    .valid_o (m1_vld),
    .res_o   (r1)
  );

  // hold the second operand alongside the first multiply
  always_ff @(posedge clk_i) begin
    c_d1_q  <= op.c;
    c_d2_q  <= c_d1_q;
    s2_d1_q <= op.s2;
    s2_d2_q <= s2_d1_q;
  end

  lls_mulrnd u_mul2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m1_vld),
    .a_i     (r1[MUL_A_W-1:0]),
    .b_i     (c_d2_q),
    .sh_i    (s2_d2_q),
    .valid_o (m2_vld),
    .res_o   (r2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= m2_vld;
    end
  end

  // clip to the 16-bit range
  always_ff @(posedge clk_i) begin
    if (r2 > SAT_MAX) begin
      val_q <= SAT_MAX[COORD_W-1:0];
      sat_q <= 1'b1;
    end else if (r2 < SAT_MIN) begin
      val_q <= SAT_MIN[COORD_W-1:0];
      sat_q <= 1'b1;
    end else begin
      val_q <= r2[COORD_W-1:0];
      sat_q <= 1'b0;
    end
  end

  assign done_o        = done_q;
  assign shape_value_o = val_q;
  assign saturated_o   = sat_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 done_o)
    else $error("accepted word did not complete after six cycles");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!start) |-> ##6 !done_o)
    else $error("result strobe without an accepted word");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (shape_value_o == 16'sh7FFF || shape_value_o == 16'sh8000))
    else $error("saturated result not on a rail");

  a_node_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && node_i == 4'd0) |-> ##6 (shape_value_o == 16'sd0 && !saturated_o))
    else $error("node zero did not give zero");
`endif

endmodule

FILE: sim/linear_lagrange_shape_function_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_lagrange_shape_function_tb
// Self-checking bench for the linear Lagrange shape function evaluator.
// Words go in through the command port with random gaps. Each strobed result
// is checked against a local model of the four element kinds, with rounding
// and saturation at the block's widths. The element kind is written and read
// back over the APB port between phases, while the pipeline is empty.
// ----------------------------------------------------------------------------
module linear_lagrange_shape_function_tb;
  import lls_pkg::*;

  localparam int LATENCY      = 6;
  localparam int DRAIN_CYCLES = LATENCY + 4;
  localparam int RUN_LIMIT    = 500000;
  localparam int REPORT_LIMIT = 200;
  localparam int PHASES       = 12;
  localparam int PHASE_WORDS  = 170;

  localparam logic [CFG_AW-1:0] ADDR_ELEMENT_KIND = CFG_AW'(4 * REG_ELEMENT_KIND);
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED     = CFG_AW'(4);

  localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;
  localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7fff;

  typedef struct {
    logic signed [COORD_W-1:0] value;
    logic                      sat;
  } shape_word_t;

  logic                      clk_i     = 1'b0;
  logic                      rst_ni    = 1'b0;
  logic                      psel      = 1'b0;
  logic                      penable   = 1'b0;
  logic                      pwrite    = 1'b0;
  logic [CFG_AW-1:0]         paddr     = '0;
  logic [CFG_DW-1:0]         pwdata    = '0;
  logic [CFG_DW-1:0]         prdata;
  logic                      pready;
  logic                      start     = 1'b0;
  logic                      busy;
  logic                      kind_i    = 1'b0;
  logic [3:0]                node_i    = '0;
  logic [1:0]                axis_i    = '0;
  logic signed [COORD_W-1:0] coord_u_i = '0;
  logic signed [COORD_W-1:0] coord_v_i = '0;
  logic signed [COORD_W-1:0] coord_w_i = '0;
  logic                      done_o;
  logic signed [COORD_W-1:0] shape_value_o;
  logic                      saturated_o;

  shape_word_t shape_results_due[$];
  elem_e       element_kind_model = EK_TRI;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  linear_lagrange_shape_function dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .node_i        (node_i),
    .axis_i        (axis_i),
    .coord_u_i     (coord_u_i),
    .coord_v_i     (coord_v_i),
    .coord_w_i     (coord_w_i),
    .done_o        (done_o),
    .shape_value_o (shape_value_o),
    .saturated_o   (saturated_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("%0t timeout, %0d results outstanding", $time, shape_results_due.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic int node_count(elem_e ek);
    case (ek)
      EK_TRI:  return 3;
      EK_HEX:  return 8;
      default: return 4;
    endcase
  endfunction

  function automatic int dim_count(elem_e ek);
    return (ek == EK_TET || ek == EK_HEX) ? 3 : 2;
  endfunction

  // divide by 2^s, round to nearest, ties away from zero
  function automatic longint round_half_away(longint x, int s);
    longint mag;
    longint r;
    mag = (x < 0) ? -x : x;
    r = (mag + (longint'(1) << (s - 1))) >>> s;
    return (x < 0) ? -r : r;
  endfunction

  function automatic shape_word_t shape_expected(elem_e ek, logic kd, logic [3:0] nd,
                                                 logic [1:0] ax,
                                                 logic signed [COORD_W-1:0] cu,
                                                 logic signed [COORD_W-1:0] cv,
                                                 logic signed [COORD_W-1:0] cw);
    shape_word_t res;
    longint one;
    longint u, v, w;
    longint su, sv, sw;
    longint fu, fv, fw;
    longint r;
    int     c;
    int     cnt;
    one = longint'(1) << FRAC_BITS;
    u = cu;
    v = cv;
    w = cw;
    cnt = node_count(ek);
    c = int'(nd) - 1;
    su = (c % 4 == 1 || c % 4 == 2) ? 1 : -1;
    sv = (c % 4 >= 2) ? 1 : -1;
    sw = (c >= 4) ? 1 : -1;
    fu = one + su * u;
    fv = one + sv * v;
    fw = one + sw * w;
    r = 0;
    if (nd < 1 || nd > cnt) begin
      r = 0;
    end else if (kd == KIND_DERIV && (ax == AX_NONE || ax > dim_count(ek))) begin
      r = 0;
    end else begin
      case (ek)
        EK_TRI, EK_TET: begin
          if (kd == KIND_VALUE) begin
            if (nd == 1) r = u;
            else if (nd == 2) r = v;
            else if (nd == 3 && ek == EK_TET) r = w;
            else r = (ek == EK_TET) ? one - u - v - w : one - u - v;
          end else if (nd == cnt) begin
            r = -one;
          end else begin
            r = (nd == ax) ? one : 0;
          end
        end
        EK_QUAD: begin
          if (kd == KIND_VALUE) r = round_half_away(fu * fv, FRAC_BITS + 2);
          else if (ax == AX_U) r = su * round_half_away(fv, 2);
          else r = sv * round_half_away(fu, 2);
        end
        default: begin
          if (kd == KIND_VALUE)
            r = round_half_away(round_half_away(fu * fv, FRAC_BITS) * fw, FRAC_BITS + 3);
          else if (ax == AX_U) r = su * round_half_away(fv * fw, FRAC_BITS + 3);
          else if (ax == AX_V) r = sv * round_half_away(fu * fw, FRAC_BITS + 3);
          else r = sw * round_half_away(fu * fv, FRAC_BITS + 3);
        end
      endcase
    end
    res.sat = 1'b0;
    if (r > 32767) begin
      r = 32767;
      res.sat = 1'b1;
    end
    if (r < -32768) begin
      r = -32768;
      res.sat = 1'b1;
    end
    res.value = COORD_W'(r);
    return res;
  endfunction

  always @(posedge clk_i) begin : check_results
    shape_word_t due;
    if (rst_ni && done_o) begin
      if (shape_results_due.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected word: expected none, got value %0d sat %0b",
                 $time, shape_value_o, saturated_o);
      end else begin
        due = shape_results_due.pop_front();
        if (due.value !== shape_value_o || due.sat !== saturated_o) begin
          mismatch_count++;
          // keep the log short on a badly broken build
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t mismatch: expected value %0d sat %0b, got value %0d sat %0b",
                     $time, due.value, due.sat, shape_value_o, saturated_o);
        end
      end
    end
  end

  // called at a rising edge; leaves start high when gap is zero
  task automatic send_word(logic kd, logic [3:0] nd, logic [1:0] ax,
                           logic signed [COORD_W-1:0] cu,
                           logic signed [COORD_W-1:0] cv,
                           logic signed [COORD_W-1:0] cw, int gap);
    start     <= 1'b1;
    kind_i    <= kd;
    node_i    <= nd;
    axis_i    <= ax;
    coord_u_i <= cu;
    coord_v_i <= cv;
    coord_w_i <= cw;
    do @(posedge clk_i); while (busy);
    shape_results_due.push_back(shape_expected(element_kind_model, kd, nd, ax, cu, cv, cw));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // start can only still be high while a word is outstanding
  task automatic wait_drained();
    if (shape_results_due.size() != 0) start <= 1'b0;
    while (shape_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ELEMENT_KIND) element_kind_model = elem_e'(data[1:0]);
    // hold the bus idle before the next transfer
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      mismatch_count++;
      $display("%0t register read mismatch: expected %0h, got %0h", $time, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper data bits are junk and must be dropped; a write off the map is ignored
  task automatic set_element_kind(elem_e ek);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    apb_write(ADDR_ELEMENT_KIND, ($urandom() & ~32'h3) | CFG_DW'(ek));
    apb_write(ADDR_UNMAPPED, $urandom());
    apb_read_check(ADDR_ELEMENT_KIND, CFG_DW'(ek));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return COORD_W'(int'($urandom_range(0, 32768)) - 16384);
      6, 7:             return COORD_W'($urandom());
      8: begin
        case ($urandom_range(0, 4))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return 16'sd16384;
          3:       return -16'sd16384;
          default: return '0;
        endcase
      end
      default: return COORD_W'(16384 * ($urandom_range(0, 1) ? 1 : -1)
                               + int'($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  // reset leaves the triangle selected
  task automatic test_reset_default();
    send_word(KIND_VALUE, 4'd1, AX_NONE, 16'sd1234, 16'sd200, 16'sd77, 0);
    send_word(KIND_VALUE, 4'd3, AX_W, C_MIN, C_MIN, C_MAX, 1);
    send_word(KIND_DERIV, 4'd3, AX_U, 16'sd5, 16'sd6, 16'sd7, 0);
    wait_drained();
  endtask

  task automatic test_register_access();
    set_element_kind(EK_HEX);
    set_element_kind(EK_TET);
    set_element_kind(EK_QUAD);
    set_element_kind(EK_TRI);
  endtask

  task automatic test_extremes();
    send_word(KIND_DERIV, 4'd1, AX_U, C_MAX, C_MAX, C_MAX, 0);
    send_word(KIND_DERIV, 4'd2, AX_U, C_MAX, C_MAX, C_MAX, 0);
    send_word(KIND_DERIV, 4'd1, AX_W, C_MIN, C_MIN, C_MIN, 0);
    send_word(KIND_DERIV, 4'd1, AX_NONE, C_MIN, C_MIN, C_MIN, 0);
    send_word(KIND_VALUE, 4'd0, AX_U, C_MAX, C_MAX, C_MAX, 0);
    set_element_kind(EK_QUAD);
    send_word(KIND_VALUE, 4'd3, AX_NONE, C_MAX, C_MAX, C_MIN, 0);
    send_word(KIND_VALUE, 4'd1, AX_NONE, C_MIN, C_MIN, C_MAX, 0);
    send_word(KIND_DERIV, 4'd1, AX_V, C_MAX, C_MIN, 16'sd3, 0);
    send_word(KIND_DERIV, 4'd4, AX_U, 16'sd3, C_MIN, 16'sd3, 0);
    send_word(KIND_VALUE, 4'd5, AX_NONE, 16'sd0, 16'sd0, 16'sd0, 0);
    set_element_kind(EK_TET);
    send_word(KIND_VALUE, 4'd4, AX_NONE, C_MIN, C_MIN, C_MIN, 0);
    send_word(KIND_VALUE, 4'd4, AX_NONE, C_MAX, C_MAX, C_MAX, 0);
    send_word(KIND_DERIV, 4'd3, AX_W, 16'sd1, 16'sd2, 16'sd3, 0);
    send_word(KIND_DERIV, 4'd4, AX_W, 16'sd1, 16'sd2, 16'sd3, 0);
    set_element_kind(EK_HEX);
    send_word(KIND_VALUE, 4'd7, AX_NONE, C_MAX, C_MAX, C_MAX, 0);
    send_word(KIND_VALUE, 4'd1, AX_NONE, C_MIN, C_MIN, C_MIN, 0);
    send_word(KIND_DERIV, 4'd8, AX_W, C_MIN, C_MAX, C_MIN, 0);
    send_word(KIND_DERIV, 4'd6, AX_V, C_MAX, C_MIN, C_MAX, 0);
    send_word(KIND_VALUE, 4'd9, AX_NONE, C_MAX, C_MAX, C_MAX, 0);
    send_word(KIND_VALUE, 4'd15, AX_NONE, C_MAX, C_MAX, C_MAX, 0);
    wait_drained();
  endtask

  task automatic test_random();
    elem_e      ek;
    logic       kd;
    logic [3:0] nd;
    logic [1:0] ax;
    bit         quiet;
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) ek = EK_TRI;
      else if (p == 1) ek = EK_HEX;
      else ek = elem_e'($urandom_range(0, 3));
      set_element_kind(ek);
      quiet = 1'b0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        // hold off once until the pipeline has emptied
        if (p == PHASES / 2 && i == PHASE_WORDS / 2) wait_drained();
        kd = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85) begin
          nd = 4'($urandom_range(1, node_count(ek)));
          ax = (kd == KIND_DERIV) ? 2'($urandom_range(1, dim_count(ek)))
                                  : 2'($urandom_range(0, 3));
        end else begin
          nd = 4'($urandom_range(0, 15));
          ax = 2'($urandom_range(0, 3));
        end
        send_word(kd, nd, ax, pick_coord(), pick_coord(), pick_coord(),
                  quiet ? 0 : pick_gap());
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_default();
    test_register_access();
    test_extremes();
    test_random();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shape_results_due.size() != 0) begin
      mismatch_count++;
      $display("%0t %0d expected words never arrived", $time, shape_results_due.size());
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/lls_pkg.sv
design/lls_decode.sv
design/lls_mulrnd.sv
design/linear_lagrange_shape_function.sv
sim/linear_lagrange_shape_function_tb.sv
